// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the character screen diff unit.
// Bodies assume a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSDB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csdb assertion failed");

// Next-cycle implication, disabled during reset.
`define CSDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csdb assertion failed");

`endif

// ===== src/csdb_pkg.sv =====
// Package of the character screen diff unit: sizes, codes, item and control types.
// No dependencies; csdb_store, csdb_apb_regs, csdb_ctrl and the top level import it.
`timescale 1ns / 1ps

package csdb_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int USE_W     = 6;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] RST_COLOR  = 8'd7;

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] chr;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_REFRESH = 2'd1,
        KIND_SWAP    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_ROW_OFFSET    = 3'd0,
        REG_COL_OFFSET    = 3'd1,
        REG_ROWS_IN_USE   = 3'd2,
        REG_COLS_IN_USE   = 3'd3,
        REG_DEFAULT_COLOR = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RD_A,
        ST_RD_B,
        ST_CAP_B,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_END
    } state_t;

    typedef struct packed {
        logic [7:0]       row_offset;
        logic [7:0]       col_offset;
        logic [USE_W-1:0] rows_in_use;
        logic [USE_W-1:0] cols_in_use;
        logic [7:0]       default_color;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] chr;
        logic [7:0] color;
    } in_item_t;

    typedef struct packed {
        logic       is_end;
        logic [8:0] screen_row;
        logic [8:0] screen_col;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       has_second;
        logic [7:0] out_color;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic              cur_buf;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_cur;
        logic              wr_both;
        logic [ADDR_W-1:0] wr_addr;
        cell_t             wr_data;
    } store_req_t;

    typedef struct packed {
        cell_t cur_data;
        cell_t oth_data;
    } store_rsp_t;

    // A cell is output when the other buffer holds byte 0 or the two differ.
    function automatic logic cell_dirty(cell_t cur, cell_t oth);
        return (oth.chr == 8'd0) || (cur != oth);
    endfunction

endpackage

// ===== src/csdb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module csdb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/csdb_store.sv =====
// Cell store: one RAM bank per buffer, mapped to current and other by the buffer select.
// Depends on csdb_pkg and csdb_ram.
`timescale 1ns / 1ps

module csdb_store (
    input  logic                  aclk,
    input  csdb_pkg::store_req_t  req,
    output csdb_pkg::store_rsp_t  rsp
);
    import csdb_pkg::*;

    logic  we0, we1;
    cell_t rd0, rd1;
    logic  sel_reg;

    assign we0 = req.wr_both || (req.wr_cur && !req.cur_buf);
    assign we1 = req.wr_both || (req.wr_cur &&  req.cur_buf);

    csdb_ram #(.WIDTH(CELL_W), .DEPTH(MEM_DEPTH)) u_bank0 (
        .aclk  (aclk),
        .we    (we0),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .raddr (req.rd_addr),
        .rdata (rd0)
    );

    csdb_ram #(.WIDTH(CELL_W), .DEPTH(MEM_DEPTH)) u_bank1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (req.wr_addr),
        .wdata (req.wr_data),
        .raddr (req.rd_addr),
        .rdata (rd1)
    );

    // Track the select of the read in flight so the data lines up.
    always_ff @(posedge aclk) begin
        sel_reg <= req.cur_buf;
    end

    assign rsp.cur_data = sel_reg ? rd1 : rd0;
    assign rsp.oth_data = sel_reg ? rd0 : rd1;

endmodule

// ===== src/csdb_apb_regs.sv =====
// APB configuration registers of the character screen diff unit.
// Depends on csdb_pkg.
`timescale 1ns / 1ps

module csdb_apb_regs (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output csdb_pkg::cfg_t cfg
);
    import csdb_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_offset    <= 8'd0;
            cfg_reg.col_offset    <= 8'd0;
            cfg_reg.rows_in_use   <= USE_W'(MAX_ROWS);
            cfg_reg.cols_in_use   <= USE_W'(MAX_COLS);
            cfg_reg.default_color <= RST_COLOR;
        end else if (wr_en) begin
            case (idx)
                REG_ROW_OFFSET:    cfg_reg.row_offset    <= pwdata[7:0];
                REG_COL_OFFSET:    cfg_reg.col_offset    <= pwdata[7:0];
                REG_ROWS_IN_USE:   cfg_reg.rows_in_use   <= pwdata[USE_W-1:0];
                REG_COLS_IN_USE:   cfg_reg.cols_in_use   <= pwdata[USE_W-1:0];
                REG_DEFAULT_COLOR: cfg_reg.default_color <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ROW_OFFSET:    prdata = {24'd0, cfg_reg.row_offset};
            REG_COL_OFFSET:    prdata = {24'd0, cfg_reg.col_offset};
            REG_ROWS_IN_USE:   prdata = {{(32-USE_W){1'b0}}, cfg_reg.rows_in_use};
            REG_COLS_IN_USE:   prdata = {{(32-USE_W){1'b0}}, cfg_reg.cols_in_use};
            REG_DEFAULT_COLOR: prdata = {24'd0, cfg_reg.default_color};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/csdb_ctrl.sv =====
// Sequencer of the character screen diff unit: init sweep, writes, row scan, swap clear,
// and the result register. Depends on csdb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csdb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  csdb_pkg::cfg_t        cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csdb_pkg::in_item_t    in_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output csdb_pkg::out_item_t   m_item,
    output csdb_pkg::store_req_t  req,
    input  csdb_pkg::store_rsp_t  rsp
);
    import csdb_pkg::*;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              cur_buf_reg, cur_buf_next;
    logic [8:0]        srow_reg, srow_next;
    cell_t             a_cur_reg, a_cur_next, a_oth_reg, a_oth_next;
    cell_t             b_cur_reg, b_cur_next, b_oth_reg, b_oth_next;
    logic              has_b_reg, has_b_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [USE_W-1:0]  nrows, ncols;
    logic              out_free;
    logic              pair, need;
    logic              load;
    out_item_t         item;

    assign nrows = (cfg.rows_in_use > USE_W'(MAX_ROWS)) ? USE_W'(MAX_ROWS) : cfg.rows_in_use;
    assign ncols = (cfg.cols_in_use > USE_W'(MAX_COLS)) ? USE_W'(MAX_COLS) : cfg.cols_in_use;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            row_reg     <= '0;
            col_reg     <= '0;
            cur_buf_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            cur_buf_reg <= cur_buf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        srow_reg   <= srow_next;
        a_cur_reg  <= a_cur_next;
        a_oth_reg  <= a_oth_next;
        b_cur_reg  <= b_cur_next;
        b_oth_reg  <= b_oth_next;
        has_b_reg  <= has_b_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cur_buf_next = cur_buf_reg;
        srow_next    = srow_reg;
        a_cur_next   = a_cur_reg;
        a_oth_next   = a_oth_reg;
        b_cur_next   = b_cur_reg;
        b_oth_next   = b_oth_reg;
        has_b_next   = has_b_reg;
        s_ready      = 1'b0;
        load         = 1'b0;
        item         = '0;
        pair         = 1'b0;
        need         = 1'b0;
        req          = '0;
        req.cur_buf  = cur_buf_reg;
        req.rd_addr  = {row_reg, col_reg};

        case (state_reg)
            ST_INIT: begin
                // sweep both banks to byte 0 in the reset color
                req.wr_both = 1'b1;
                req.wr_addr = {row_reg, col_reg};
                req.wr_data = '{color: RST_COLOR, chr: 8'd0};
                {row_next, col_next} = ADDR_W'({row_reg, col_reg}) + ADDR_W'(1);
                if (&{row_reg, col_reg}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (kind_t'(in_item.kind))
                        KIND_WRITE: begin
                            if (USE_W'(in_item.row) < nrows && USE_W'(in_item.col) < ncols) begin
                                req.wr_cur  = 1'b1;
                                req.wr_addr = {ROW_W'(in_item.row), COL_W'(in_item.col)};
                                req.wr_data = '{color: in_item.color, chr: in_item.chr};
                            end
                        end
                        KIND_REFRESH: begin
                            srow_next = 9'(in_item.row) + 9'(cfg.row_offset);
                            row_next  = ROW_W'(in_item.row);
                            col_next  = '0;
                            if (USE_W'(in_item.row) < nrows && ncols != '0) begin
                                state_next = ST_RD_A;
                            end else begin
                                state_next = ST_END;
                            end
                        end
                        KIND_SWAP: begin
                            cur_buf_next = !cur_buf_reg;
                            row_next     = '0;
                            col_next     = '0;
                            if (nrows != '0 && ncols != '0) begin
                                state_next = ST_CLEAR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                req.wr_cur  = 1'b1;
                req.wr_addr = {row_reg, col_reg};
                req.wr_data = '{color: cfg.default_color, chr: SPACE_BYTE};
                if (USE_W'(col_reg) + USE_W'(1) == ncols) begin
                    col_next = '0;
                    if (USE_W'(row_reg) + USE_W'(1) == nrows) begin
                        state_next = ST_IDLE;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            ST_RD_A: begin
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                // capture the even column, fetch its right neighbor if in use
                a_cur_next  = rsp.cur_data;
                a_oth_next  = rsp.oth_data;
                req.rd_addr = {row_reg, col_reg + COL_W'(1)};
                has_b_next  = (USE_W'(col_reg) + USE_W'(1)) < ncols;
                state_next  = has_b_next ? ST_CAP_B : ST_EMIT_A;
            end
            ST_CAP_B: begin
                b_cur_next = rsp.cur_data;
                b_oth_next = rsp.oth_data;
                state_next = ST_EMIT_A;
            end
            ST_EMIT_A: begin
                pair = has_b_reg && a_cur_reg.chr[7] && b_cur_reg.chr[7];
                need = cell_dirty(a_cur_reg, a_oth_reg) ||
                       (pair && cell_dirty(b_cur_reg, b_oth_reg));
                if (!need || out_free) begin
                    if (need) begin
                        load             = 1'b1;
                        item.screen_row  = srow_reg;
                        item.screen_col  = 9'(col_reg) + 9'(cfg.col_offset);
                        item.first_byte  = a_cur_reg.chr;
                        item.second_byte = pair ? b_cur_reg.chr : 8'd0;
                        item.has_second  = pair;
                        item.out_color   = a_cur_reg.color;
                        if (pair) begin
                            // trailing cell takes the other buffer's value
                            req.wr_cur  = 1'b1;
                            req.wr_addr = {row_reg, col_reg + COL_W'(1)};
                            req.wr_data = b_oth_reg;
                            b_cur_next  = b_oth_reg;
                        end
                    end
                    state_next = has_b_reg ? ST_EMIT_B : ST_END;
                end
            end
            ST_EMIT_B: begin
                need = cell_dirty(b_cur_reg, b_oth_reg);
                if (!need || out_free) begin
                    if (need) begin
                        load            = 1'b1;
                        item.screen_row = srow_reg;
                        item.screen_col = 9'(col_reg) + 9'(cfg.col_offset) + 9'd1;
                        item.first_byte = b_cur_reg.chr;
                        item.out_color  = b_cur_reg.color;
                    end
                    if (USE_W'(col_reg) + USE_W'(2) < ncols) begin
                        col_next   = col_reg + COL_W'(2);
                        state_next = ST_RD_A;
                    end else begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    load            = 1'b1;
                    item.is_end     = 1'b1;
                    item.screen_row = srow_reg;
                    item.last       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = item;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_data_reg;

    // leaving the end state always leaves the row end marker in the result register
    `CSDB_ASSERT_NEXT(a_end_loaded, (state_reg == ST_END && state_next == ST_IDLE), (m_valid_reg && m_data_reg.last && m_data_reg.is_end))
    // the pair write-back hits the odd trailing column only
    `CSDB_ASSERT_IMPL(a_pair_wr_odd, (state_reg == ST_EMIT_A && req.wr_cur), (req.wr_addr[0] == 1'b1))
    // the buffer select holds for the whole row scan
    `CSDB_ASSERT_NEXT(a_buf_stable, (state_reg == ST_RD_A || state_reg == ST_RD_B || state_reg == ST_CAP_B || state_reg == ST_EMIT_A || state_reg == ST_EMIT_B || state_reg == ST_END), $stable(cur_buf_reg))

endmodule

// ===== src/char_screen_double_buffer_diff_unit.sv =====
// Top level of the character screen diff unit: ports, item packing and submodules.
// Depends on csdb_pkg, csdb_apb_regs, csdb_store and csdb_ctrl.
`timescale 1ns / 1ps

// Double-buffered character screen with dirty-cell row refresh.
// Input channel (s_*): one item per handshake; s_tuser carries the kind
// (write cell, refresh row, swap and clear), s_tdata the cell fields.
// Result channel (m_*): refresh items only; each dirty cell or double-byte
// pair of the row is one item, then an end marker with tlast high.
// Configuration: APB, registers at 4*i, to be written by the user while
// the block is idle; the block itself does not enforce this.
// Operation: items are taken only in idle; a write then completes at once. A
// refresh walks the row two columns at a time through the registered read
// of the two cell banks, then loads the end marker. A swap clears rows*cols
// cells, one cell a cycle through the bank write port. One item is in work
// at a time. Reset: both banks are swept to byte 0 in color 7, one entry per
// cycle; no item is taken meanwhile, configuration writes are.
// Stall: results sit in one output register; the scan holds while that
// register is full and not taken, and resumes without loss.

module char_screen_double_buffer_diff_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: cell_row[4:0], cell_col[9:5], cell_byte[17:10], cell_color[25:18], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // s_tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    // m_tdata: screen_row[8:0], screen_col[17:9], first_byte[25:18],
    //          second_byte[33:26], out_color[41:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // m_tuser: is_end[0], has_second[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import csdb_pkg::*;

    cfg_t       cfg;
    in_item_t   in_item;
    out_item_t  out_item;
    store_req_t req;
    store_rsp_t rsp;

    // unpack the input item
    assign in_item.kind  = s_tuser;
    assign in_item.row   = s_tdata[4:0];
    assign in_item.col   = s_tdata[9:5];
    assign in_item.chr   = s_tdata[17:10];
    assign in_item.color = s_tdata[25:18];

    csdb_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csdb_store u_store (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    csdb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .in_item (in_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (out_item),
        .req     (req),
        .rsp     (rsp)
    );

    // pack the result item
    assign m_tdata = {6'd0, out_item.out_color, out_item.second_byte, out_item.first_byte,
                      out_item.screen_col, out_item.screen_row};
    assign m_tuser = {out_item.has_second, out_item.is_end};
    assign m_tlast = out_item.last;

endmodule
